// ===== hdl/pcts_pkg.sv =====
// passcode table store: shared payload types, operation codes and the
// command/status bundles between controller and datapath. no dependencies.
package pcts_pkg;

  localparam int PASSCODE_W = 64;
  localparam int BYTE_W     = 8;
  localparam int MAX_KEY_BYTES = PASSCODE_W / BYTE_W;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [PASSCODE_W-1:0] passcode;
  } pcts_in_t;

  typedef struct packed {
    logic success;
    logic table_full;
    logic table_empty;
  } pcts_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input word, rewind slot index
    logic step;    // advance slot index
    logic rd;      // key read issued for current slot
    logic wr;      // store key in current slot and mark it valid
    logic clr;     // drop every valid mark
    logic set_ok;  // success flag
    logic emit;    // load result register
  } pcts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       slot_free;
    logic       idx_last;
    logic       out_busy;
  } pcts_sts_t;

endpackage

// ===== hdl/pcts_dp.sv =====
// passcode table store datapath: key memory, valid marks, slot index,
// match compare and result register. uses pcts_pkg.
module pcts_dp #(
  parameter int SLOTS     = 8,
  parameter int KEY_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcts_pkg::pcts_in_t  in_data_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output pcts_pkg::pcts_out_t out_data_o,
  input  pcts_pkg::pcts_cmd_t cmd_i,
  output pcts_pkg::pcts_sts_t sts_o
);
  import pcts_pkg::*;

  localparam int KEY_W = KEY_BYTES * BYTE_W;
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] rd_data_q;
  logic [1:0]       op_q;
  logic [IW-1:0]    idx_q;
  logic [SLOTS-1:0] valid_q;
  logic             rd_live_q;
  logic             rd_vld_q;
  logic             ok_q;
  logic             out_valid_q;
  pcts_out_t        out_q;
  logic             match;

  // only the low key bytes are stored and compared
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_data_i.passcode[KEY_W-1:0];
      op_q  <= in_data_i.cmd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      key_mem[idx_q] <= key_q;
    end
    rd_data_q <= key_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      valid_q   <= '0;
      rd_live_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      ok_q      <= 1'b0;
    end else begin
      rd_live_q <= cmd_i.rd;
      rd_vld_q  <= valid_q[idx_q];
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.clr) begin
        valid_q <= '0;
      end else if (cmd_i.wr) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (cmd_i.load) begin
        ok_q <= 1'b0;
      end else if (cmd_i.set_ok || match) begin
        ok_q <= 1'b1;
      end
    end
  end

  // compare in the cycle after the read, gated by the slot's valid mark
  assign match = rd_live_q && rd_vld_q && (rd_data_q == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.success     <= ok_q;
      out_q.table_full  <= &valid_q;
      out_q.table_empty <= ~|valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.op        = op_q;
  assign sts_o.slot_free = ~valid_q[idx_q];
  assign sts_o.idx_last  = (idx_q == IW'(SLOTS - 1));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

endmodule

// ===== hdl/pcts_ctrl.sv =====
// passcode table store controller: sequences add, query and clear over
// the slots of the datapath. uses pcts_pkg.
module pcts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output pcts_pkg::pcts_cmd_t cmd_o,
  input  pcts_pkg::pcts_sts_t sts_i
);
  import pcts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_QUERY,
    ST_DRAIN,
    ST_CLEAR,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RESULT;
          case (sts_i.op)
            OP_ADD:   state_d = ST_ADD;
            OP_QUERY: state_d = ST_QUERY;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_RESULT;
          endcase
        end
      end
      ST_ADD: begin
        // walk up from slot 0, take the first free one
        if (sts_i.slot_free) begin
          cmd_o.wr     = 1'b1;
          cmd_o.set_ok = 1'b1;
          state_d      = ST_RESULT;
        end else if (sts_i.idx_last) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_QUERY: begin
        cmd_o.rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DRAIN: begin
        // last slot's compare lands here
        state_d = ST_RESULT;
      end
      ST_CLEAR: begin
        cmd_o.clr    = 1'b1;
        cmd_o.set_ok = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/passcode_table_store_top.sv =====
// Passcode table store, top level. One word is taken at a time; the block
// stalls its input until that word's result sits in the output register.
// Clear goes through the clear state to the result state, an unused command
// code straight to the result state, add walks the slots up from slot 0 until
// a free one, and query reads every slot's key and drains a registered compare.
// A result waiting on the output does not stop the next word from being
// accepted. Keys are held in a single-port memory, the valid marks in flops
// cleared by reset.
// uses pcts_pkg, pcts_ctrl and pcts_dp.
module passcode_table_store_top #(
  parameter int SLOTS     = 8,
  parameter int KEY_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pcts_pkg::pcts_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pcts_pkg::pcts_out_t out_data_o
);
  import pcts_pkg::*;

  pcts_cmd_t cmd;
  pcts_sts_t sts;
  pcts_sts_t sts_mux;

  // op code is taken straight from the input while idle so the first
  // state can be chosen at acceptance
  always_comb begin
    sts_mux = sts;
    if (!in_stall_o) begin
      sts_mux.op = in_data_i.cmd;
    end
  end

  pcts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts_mux)
  );

  pcts_dp #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== dv/tb.sv =====
// testbench for passcode_table_store_top: directed and random add/query/clear words,
// random idling on both sides, and a long output hold-off that backs up the input.
// depends on pcts_pkg and the passcode_table_store_top rtl.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcts_pkg::*;

  localparam int N_SLOTS     = 8;
  localparam int N_KEY_BYTES = 8;
  localparam int N_RANDOM    = 650;
  localparam logic [1:0] OP_SPARE = 2'd3;  // unused command code
  localparam int HOLD_CYCLES = 200;

  // tracks the slot table and the status words it should produce
  class passcode_book;
    bit [N_SLOTS-1:0]    in_use;
    logic [63:0]         keys [N_SLOTS];
    pcts_pkg::pcts_out_t status_due [$];
    int mismatches;
    int statuses_seen;
    int hits;
    int misses;
    int refusals;
    int full_seen;

    function new();
      in_use = '0;
    endfunction

    function logic [63:0] key_mask();
      if (N_KEY_BYTES >= 8) return '1;
      return (64'd1 << (8 * N_KEY_BYTES)) - 64'd1;
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    function void note_word(pcts_pkg::pcts_in_t w);
      logic [63:0]         k;
      pcts_pkg::pcts_out_t s;
      k = w.passcode & key_mask();
      s = '0;
      case (w.cmd)
        pcts_pkg::OP_ADD: begin
          // lowest free slot takes the key
          for (int i = 0; i < N_SLOTS; i++) begin
            if (!in_use[i] && !s.success) begin
              in_use[i] = 1'b1;
              keys[i]   = k;
              s.success = 1'b1;
            end
          end
          if (!s.success) refusals++;
        end
        pcts_pkg::OP_QUERY: begin
          for (int i = 0; i < N_SLOTS; i++) begin
            if (in_use[i] && keys[i] == k) s.success = 1'b1;
          end
          if (s.success) hits++;
          else misses++;
        end
        pcts_pkg::OP_CLEAR: begin
          in_use    = '0;
          s.success = 1'b1;
        end
        default: ;
      endcase
      s.table_full  = &in_use;
      s.table_empty = ~|in_use;
      if (s.table_full) full_seen++;
      status_due.push_back(s);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
    endtask

    task check_status(pcts_pkg::pcts_out_t got);
      pcts_pkg::pcts_out_t want;
      statuses_seen++;
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("status word %b with none pending", got));
      end else begin
        want = status_due.pop_front();
        if (got.success !== want.success)
          report_mismatch($sformatf("success %b, want %b", got.success, want.success));
        if (got.table_full !== want.table_full)
          report_mismatch($sformatf("table_full %b, want %b", got.table_full, want.table_full));
        if (got.table_empty !== want.table_empty)
          report_mismatch($sformatf("table_empty %b, want %b", got.table_empty,
                                    want.table_empty));
      end
    endtask
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  pcts_in_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  pcts_out_t out_data_o;

  passcode_book book = new();

  logic [63:0] key_history [$];
  int          words_sent = 0;
  bit          quiet      = 1'b0;
  bit          hold_done  = 1'b0;

  always #1 clk_i = ~clk_i;

  passcode_table_store_top #(
    .SLOTS     (N_SLOTS),
    .KEY_BYTES (N_KEY_BYTES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_status(out_data_o);
  end

  // output side: random stalls, one long hold-off so the block backs up
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && words_sent >= 420) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(pcts_in_t w);
    quiet = (words_sent >= 150 && words_sent < 300);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    book.note_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_op(logic [1:0] op, logic [63:0] key);
    pcts_in_t w;
    w.cmd      = op;
    w.passcode = key;
    if (op == OP_ADD) begin
      key_history.push_back(key);
      if (key_history.size() > 32) void'(key_history.pop_front());
    end
    send_word(w);
  endtask

  function automatic logic [63:0] pick_key(logic [1:0] op);
    int          r;
    logic [63:0] old;
    r = $urandom_range(99);
    if (key_history.size() != 0) begin
      old = key_history[$urandom_range(key_history.size() - 1)];
      if (op == OP_QUERY && r < 55) return old;
      // near miss: one bit off a known key
      if (op == OP_QUERY && r < 75) return old ^ (64'd1 << $urandom_range(63));
      if (op == OP_ADD && r < 15) return old;
    end
    if (r >= 95) return {64{r[0]}};
    return {$urandom, $urandom};
  endfunction

  task automatic run_directed();
    send_op(OP_QUERY, 64'h0);
    send_op(OP_SPARE, '1);
    send_op(OP_CLEAR, 64'h0);
    send_op(OP_ADD,   64'h0);
    send_op(OP_ADD,   '1);
    send_op(OP_QUERY, 64'h0);
    send_op(OP_QUERY, '1);
    send_op(OP_QUERY, 64'h1);
    send_op(OP_ADD,   64'h0123_4567_89ab_cdef);
    send_op(OP_ADD,   64'h0123_4567_89ab_cdef);
    send_op(OP_ADD,   64'h8000_0000_0000_0000);
    send_op(OP_ADD,   64'h0000_0000_0000_0001);
    send_op(OP_ADD,   64'h5555_aaaa_5555_aaaa);
    send_op(OP_ADD,   64'haaaa_5555_aaaa_5555);
    // table is full now, this one is refused
    send_op(OP_ADD,   64'hdead_beef_0000_0001);
    send_op(OP_QUERY, 64'h0123_4567_89ab_cdef);
    send_op(OP_QUERY, 64'hdead_beef_0000_0001);
    send_op(OP_SPARE, 64'h0);
    send_op(OP_QUERY, 64'h8000_0000_0000_0000);
    send_op(OP_CLEAR, '1);
    // keys stay in memory after a clear but must not match
    send_op(OP_QUERY, '1);
    send_op(OP_ADD,   64'hff00_ff00_ff00_ff00);
    send_op(OP_QUERY, 64'hff00_ff00_ff00_ff00);
    send_op(OP_QUERY, 64'h0);
  endtask

  task automatic run_random();
    int          r;
    logic [1:0]  op;
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(99);
      if (r < 44) op = OP_ADD;
      else if (r < 89) op = OP_QUERY;
      else if (r < 95) op = OP_CLEAR;
      else op = OP_SPARE;
      send_op(op, pick_key(op));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (2 * (N_SLOTS + 2)) @(posedge clk_i);
    $display("%0d words sent, %0d status words checked, full table seen %0d times",
             words_sent, book.statuses_seen, book.full_seen);
    $display("query hits %0d, query misses %0d, adds refused on a full table %0d",
             book.hits, book.misses, book.refusals);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("timeout with %0d status words pending", book.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
